// File: rtl/ssrq_pkg.sv
// Package for the sorted store rank query core.
// Holds the default sizes, field widths, input kind codes and the result record type.
// It depends on nothing and is compiled first.
package ssrq_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam int IN_VALUE_W = 32;
	localparam int RANK_W     = 11;
	localparam int M_TDATA_W  = 24;
	localparam int M_TUSER_W  = 2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef struct packed {
		logic              empty_res;
		logic              dropped;
		logic [RANK_W-1:0] total;
		logic [RANK_W-1:0] rank;
	} res_t;

endpackage

// File: rtl/ssrq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters. It depends on nothing.
module ssrq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/ssrq_seq.sv
// Sequencer of the sorted store rank query core: insertion shift and binary search.
// One shared magnitude comparator serves both. Uses ssrq_pkg and drives an ssrq_ram.
module ssrq_seq #(
	parameter int CAPACITY   = ssrq_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = ssrq_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_kind,
	input  logic [ssrq_pkg::IN_VALUE_W-1:0]   in_value,
	output logic                              res_valid,
	input  logic                              res_ready,
	output ssrq_pkg::res_t                    res,
	output logic                              ram_we,
	output logic [$clog2(CAPACITY)-1:0]       ram_waddr,
	output logic [VALUE_BITS-1:0]             ram_wdata,
	output logic                              ram_re,
	output logic [$clog2(CAPACITY)-1:0]       ram_raddr,
	input  logic [VALUE_BITS-1:0]             ram_rdata
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_PLACE = 3'd2;
	localparam logic [2:0] ST_QRD   = 3'd3;
	localparam logic [2:0] ST_QCMP  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [AW-1:0]         hole_q;
	logic [CNT_W-1:0]      lo_q;
	logic [CNT_W-1:0]      hi_q;
	logic [AW-1:0]         mid_q;
	logic [CNT_W-1:0]      rank_q;
	logic                  dropped_q;
	logic                  empty_q;

	logic [VALUE_BITS-1:0] in_v;
	logic                  gt;
	logic [CNT_W-1:0]      cnt_m1;
	logic [CNT_W-1:0]      span;
	logic [CNT_W-1:0]      mid_w;
	logic [CNT_W-1:0]      lo_n;
	logic [CNT_W-1:0]      hi_n;
	logic [AW-1:0]         hole_m1;
	logic [AW-1:0]         hole_m2;
	logic                  accept;

	assign in_v    = VALUE_BITS'(in_value);
	assign gt      = ram_rdata > v_q;
	assign cnt_m1  = count_q - CNT_W'(1);
	assign span    = hi_q - lo_q;
	assign mid_w   = lo_q + (span >> 1);
	assign lo_n    = gt ? lo_q : (CNT_W'(mid_q) + CNT_W'(1));
	assign hi_n    = gt ? CNT_W'(mid_q) : hi_q;
	assign hole_m1 = hole_q - AW'(1);
	assign hole_m2 = hole_q - AW'(2);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign res_valid     = (state_q == ST_DONE);
	assign res.rank      = ssrq_pkg::RANK_W'(rank_q);
	assign res.total     = ssrq_pkg::RANK_W'(count_q);
	assign res.dropped   = dropped_q;
	assign res.empty_res = empty_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = v_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_kind == ssrq_pkg::KIND_INSERT) begin
					if (count_q == '0) begin
						ram_we    = 1'b1;
						ram_wdata = in_v;
					end else if (count_q != CNT_W'(CAPACITY)) begin
						ram_re    = 1'b1;
						ram_raddr = cnt_m1[AW-1:0];
					end
				end
			end
			ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = hole_q;
				ram_wdata = gt ? ram_rdata : v_q;
				if (gt && hole_q != AW'(1)) begin
					ram_re    = 1'b1;
					ram_raddr = hole_m2;
				end
			end
			ST_PLACE: begin
				ram_we = 1'b1;
			end
			ST_QRD: begin
				ram_re    = 1'b1;
				ram_raddr = mid_w[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_kind == ssrq_pkg::KIND_INSERT) begin
							if (count_q == CNT_W'(CAPACITY)) begin
								state_q <= ST_DONE;
							end else if (count_q == '0) begin
								count_q <= CNT_W'(1);
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_SHIFT;
							end
						end else begin
							state_q <= (count_q == '0) ? ST_DONE : ST_QRD;
						end
					end
				end
				ST_SHIFT: begin
					if (!gt) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_DONE;
					end else if (hole_q == AW'(1)) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= ST_DONE;
				end
				ST_QRD: begin
					state_q <= ST_QCMP;
				end
				ST_QCMP: begin
					state_q <= (lo_n < hi_n) ? ST_QRD : ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q       <= in_v;
			hole_q    <= count_q[AW-1:0];
			lo_q      <= '0;
			hi_q      <= count_q;
			rank_q    <= '0;
			dropped_q <= (in_kind == ssrq_pkg::KIND_INSERT) && (count_q == CNT_W'(CAPACITY));
			empty_q   <= (in_kind == ssrq_pkg::KIND_QUERY) && (count_q == '0);
		end
		if (state_q == ST_SHIFT && gt) begin
			hole_q <= hole_m1;
		end
		if (state_q == ST_QRD) begin
			mid_q <= mid_w[AW-1:0];
		end
		if (state_q == ST_QCMP) begin
			lo_q   <= lo_n;
			hi_q   <= hi_n;
			rank_q <= lo_n;
		end
	end

endmodule

// File: rtl/sorted_store_rank_query_core.sv
// The core keeps up to CAPACITY values in ascending order in one RAM and answers rank
// queries over them. An insert moves each stored value larger than the new one up by one
// place, as the single RAM write port moves one entry per cycle; an insert into an empty
// or a full store needs no shift. A query runs a binary search in which each step is a
// registered RAM read followed by a compare, and a query on an empty store needs no search.
// A result then waits in the output register, and the next transaction is taken while it
// waits. The store needs no clearing after reset.
// Uses ssrq_pkg, ssrq_seq and ssrq_ram.
module sorted_store_rank_query_core #(
	parameter int CAPACITY   = ssrq_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = ssrq_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ssrq_pkg::IN_VALUE_W-1:0]     s_tdata,  // value
	input  logic [0:0]                          s_tuser,  // kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ssrq_pkg::M_TDATA_W-1:0]      m_tdata,  // rank, total, zero pad
	output logic [ssrq_pkg::M_TUSER_W-1:0]      m_tuser   // dropped, empty_res
);

	localparam int AW = $clog2(CAPACITY);

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [VALUE_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [VALUE_BITS-1:0] ram_rdata;
	logic                  res_valid;
	logic                  res_ready;
	ssrq_pkg::res_t        res;
	logic                  m_tvalid_q;
	ssrq_pkg::res_t        out_q;

	ssrq_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ssrq_seq #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser[0]),
		.in_value  (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(ssrq_pkg::M_TDATA_W - 2 * ssrq_pkg::RANK_W){1'b0}},
		out_q.total, out_q.rank};
	assign m_tuser  = {out_q.empty_res, out_q.dropped};

endmodule

// File: rtl/ssrq_chk.sv
// Port checker for the sorted store rank query core, bound to the top level.
// Uses ssrq_pkg for the port widths.
module ssrq_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [ssrq_pkg::IN_VALUE_W-1:0] s_tdata,
	input logic [0:0]                      s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ssrq_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic [ssrq_pkg::M_TUSER_W-1:0]  m_tuser
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Output transaction changed while stalled.");

	// An accepted transaction makes the core busy, so it refuses input in the cycle after.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted on two consecutive cycles.");

	// A refused insert or an empty query carries a zero rank, and the two flags are never set together.
	a_flag_rank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata[10:0] == 11'd0 && !(m_tuser[0] && m_tuser[1]))
		else $error("Flagged result with a nonzero rank or both flags set.");

	// An empty query reports an empty store.
	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[21:11] == 11'd0)
		else $error("Empty query with a nonzero total.");

endmodule

bind sorted_store_rank_query_core ssrq_chk u_ssrq_chk (.*);

// File: bench/tb_top.sv
// Self-checking testbench for sorted_store_rank_query_core: directed and random inserts and
// rank queries over the stream ports, checked against a behavioral sorted store kept here.
// Depends on ssrq_pkg and the core with its submodules; reads no files.
`timescale 1ns / 1ps

module tb_top;
	import ssrq_pkg::*;

	typedef struct {
		logic                  kind;
		logic [IN_VALUE_W-1:0] value;
		bit                    typed;
		res_t                  fixed;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_VALUE_W-1:0] s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;

	logic [IN_VALUE_W-1:0] store_mem [CAPACITY_DEF];
	int                    held = 0;
	res_t                  pending_q [$];
	step_t                 plan_q [$];
	int                    errors = 0;
	int                    results_seen = 0;
	int                    sent_n = 0;
	int                    tx_level = 0;
	int                    rx_level = 0;
	int                    rx_hold = 0;
	int                    rx_cycles = 0;
	bit                    calm = 1'b0;
	logic [IN_VALUE_W-1:0] fill_v;

	sorted_store_rank_query_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100ms;
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic report(input string msg);
		errors++;
		if (errors <= 100) begin
			$display("tb_top: mismatch at result %0d: %s", results_seen, msg);
		end
	endtask

	function automatic res_t apply_item(input logic kind, input logic [IN_VALUE_W-1:0] v);
		res_t r;
		int   slot;
		int   hits;
		r = '0;
		if (kind == KIND_INSERT) begin
			if (held == CAPACITY_DEF) begin
				r.dropped = 1'b1;
			end else begin
				slot = held;
				while (slot > 0 && store_mem[slot-1] > v) begin
					store_mem[slot] = store_mem[slot-1];
					slot--;
				end
				store_mem[slot] = v;
				held++;
			end
		end else if (held == 0) begin
			r.empty_res = 1'b1;
		end else begin
			hits = 0;
			for (int i = 0; i < held; i++) begin
				if (store_mem[i] <= v)
					hits++;
			end
			r.rank = hits[RANK_W-1:0];
		end
		r.total = held[RANK_W-1:0];
		return r;
	endfunction

	function automatic logic [IN_VALUE_W-1:0] pick_value();
		logic [IN_VALUE_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = $urandom_range(0, 7);
			3, 4:    v = (held > 0) ? store_mem[$urandom_range(0, held - 1)] : '0;
			5:       v = $urandom_range(0, 1) ? '1 : '0;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	task automatic row(input logic kind, input logic [IN_VALUE_W-1:0] v, input bit typed,
			input int rk, input int tot, input bit drp, input bit emp);
		step_t s;
		s.kind            = kind;
		s.value           = v;
		s.typed           = typed;
		s.fixed           = '0;
		s.fixed.rank      = rk[RANK_W-1:0];
		s.fixed.total     = tot[RANK_W-1:0];
		s.fixed.dropped   = drp;
		s.fixed.empty_res = emp;
		plan_q.push_back(s);
	endtask

	// Called right after a rising edge; returns right after the accepting edge or a gap.
	task automatic send_item(input logic kind, input logic [IN_VALUE_W-1:0] v, input bit typed,
			input res_t fixed);
		res_t want;
		int   gap;
		if (sent_n % 32 == 0)
			tx_level = $urandom_range(0, 3);
		sent_n++;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		want = apply_item(kind, v);
		pending_q.push_back(typed ? fixed : want);
		gap = 0;
		if (!calm && tx_level != 0 && $urandom_range(0, 7) < tx_level)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	task automatic send_random(input logic kind);
		send_item(kind, pick_value(), 1'b0, '0);
	endtask

	always @(posedge clk) begin
		rx_cycles <= rx_cycles + 1;
		if (rx_cycles % 100 == 0)
			rx_level <= $urandom_range(0, 3);
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else if (!calm && rx_level != 0 && $urandom_range(0, 11) < rx_level) begin
			m_tready <= 1'b0;
			rx_hold  <= $urandom_range(1, 8) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				report($sformatf("result with nothing pending, tdata %h tuser %h",
					m_tdata, m_tuser));
			end else begin
				want = pending_q.pop_front();
				if (m_tdata[RANK_W-1:0] !== want.rank)
					report($sformatf("rank %0d, expected %0d",
						m_tdata[RANK_W-1:0], want.rank));
				if (m_tdata[2*RANK_W-1:RANK_W] !== want.total)
					report($sformatf("total %0d, expected %0d",
						m_tdata[2*RANK_W-1:RANK_W], want.total));
				if (m_tuser[0] !== want.dropped)
					report($sformatf("dropped %b, expected %b", m_tuser[0], want.dropped));
				if (m_tuser[1] !== want.empty_res)
					report($sformatf("empty_res %b, expected %b", m_tuser[1], want.empty_res));
			end
			results_seen++;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store, equal values at the head, values below and above all entries.
		row(KIND_QUERY,  32'h0000_0000, 1'b1, 0, 0, 1'b0, 1'b1);
		row(KIND_QUERY,  32'hFFFF_FFFF, 1'b1, 0, 0, 1'b0, 1'b1);
		row(KIND_INSERT, 32'h0000_0005, 1'b1, 0, 1, 1'b0, 1'b0);
		row(KIND_QUERY,  32'h0000_0004, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_QUERY,  32'h0000_0005, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_INSERT, 32'h0000_0005, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_INSERT, 32'h0000_0005, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_QUERY,  32'h0000_0005, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_INSERT, 32'h0000_0000, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_INSERT, 32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_QUERY,  32'hFFFF_FFFF, 1'b1, 5, 5, 1'b0, 1'b0);
		row(KIND_QUERY,  32'h0000_0000, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_INSERT, 32'h0000_0000, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_QUERY,  32'h0000_0000, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_INSERT, 32'h7FFF_FFFF, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_INSERT, 32'h8000_0000, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_QUERY,  32'h7FFF_FFFF, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_QUERY,  32'h8000_0000, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_QUERY,  32'hFFFF_FFFE, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_INSERT, 32'hAAAA_AAAA, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_INSERT, 32'h5555_5555, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_QUERY,  32'h5555_5555, 1'b0, 0, 0, 1'b0, 1'b0);
		row(KIND_QUERY,  32'h0000_0006, 1'b0, 0, 0, 1'b0, 1'b0);
		foreach (plan_q[i])
			send_item(plan_q[i].kind, plan_q[i].value, plan_q[i].typed, plan_q[i].fixed);
		drain();

		for (int i = 0; i < 450; i++) begin
			send_random(($urandom_range(0, 99) < 55) ? KIND_INSERT : KIND_QUERY);
			if (i == 225)
				drain();
		end

		// Fill the store with mostly rising values, so that inserts stay short.
		fill_v = 32'hC000_0000;
		while (held < CAPACITY_DEF) begin
			if (held >= CAPACITY_DEF - 24)
				calm = 1'b1;
			if ($urandom_range(0, 15) == 0) begin
				send_random(KIND_QUERY);
			end else begin
				send_item(KIND_INSERT, fill_v, 1'b0, '0);
				fill_v = fill_v + $urandom_range(0, 3);
			end
		end

		// Full store: inserts are refused and queries reach the largest rank.
		calm = 1'b1;
		send_item(KIND_QUERY, 32'hFFFF_FFFF, 1'b0, '0);
		send_item(KIND_INSERT, 32'h0000_0000, 1'b0, '0);
		send_item(KIND_INSERT, 32'hFFFF_FFFF, 1'b0, '0);
		send_item(KIND_QUERY, 32'h0000_0000, 1'b0, '0);
		for (int i = 0; i < 30; i++)
			send_random($urandom_range(0, 1) ? KIND_QUERY : KIND_INSERT);

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
		repeat (1100) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
